// ----- rtl/core/xcfr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the xor checked frame receiver
// no dependencies

package xcfr_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_ACK_CODE   = 2'd1;
  localparam logic [1:0] REG_NAK_CODE   = 2'd2;

  // register reset values
  localparam logic [7:0] START_BYTE_RST = 8'h01;
  localparam logic [7:0] ACK_CODE_RST   = 8'd6;
  localparam logic [7:0] NAK_CODE_RST   = 8'd21;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration seen by front and back
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
  } cfg_t;

  // work for the back part caused by one input beat
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic [7:0] pay_pos;
    logic [7:0] pay_cmd;
    logic       has_ver;
    logic       ver_ok;
    logic [7:0] ver_cmd;
  } entry_t;

endpackage

// ----- rtl/core/xcfr_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for received bytes and results
// depends on nothing

interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [7:0] position;
  logic [7:0] command;
  logic       last;

  modport source (output valid, output kind, output value, output position,
                  output command, output last, input ready);
  modport sink (input valid, input kind, input value, input position,
                input command, input last, output ready);
endinterface

// ----- rtl/core/xcfr_regs.sv -----
`timescale 1ns / 1ps
// apb-style configuration registers: start byte, ack code, nak code
// depends on xcfr_pkg

module xcfr_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output xcfr_pkg::cfg_t      cfg
);

  xcfr_pkg::cfg_t cfg_r;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= xcfr_pkg::START_BYTE_RST;
      cfg_r.ack_code   <= xcfr_pkg::ACK_CODE_RST;
      cfg_r.nak_code   <= xcfr_pkg::NAK_CODE_RST;
    end else if (wr_en) begin
      case (idx)
        xcfr_pkg::REG_START_BYTE: cfg_r.start_byte <= pwdata[7:0];
        xcfr_pkg::REG_ACK_CODE:   cfg_r.ack_code   <= pwdata[7:0];
        xcfr_pkg::REG_NAK_CODE:   cfg_r.nak_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      xcfr_pkg::REG_START_BYTE: prdata = {24'd0, cfg_r.start_byte};
      xcfr_pkg::REG_ACK_CODE:   prdata = {24'd0, cfg_r.ack_code};
      xcfr_pkg::REG_NAK_CODE:   prdata = {24'd0, cfg_r.nak_code};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/xcfr_front.sv -----
`timescale 1ns / 1ps
// front part: frame parser that turns received beats into queue work
// depends on xcfr_pkg and xcfr_if

module xcfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  xcfr_pkg::cfg_t    cfg,
  xcfr_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output xcfr_pkg::entry_t  push_entry
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CHECK = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;

  logic       take;
  logic [7:0] b;
  logic [7:0] xor_new;
  logic       final_byte;
  xcfr_pkg::entry_t ent;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;
  assign xor_new     = xor_r ^ b;
  assign final_byte  = ({1'b0, cnt_r} + 9'd1) >= {1'b0, len_r};

  // next state and the work this beat causes
  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    ent       = '0;
    case (phase_r)
      PH_CHECK: begin
        exp_nxt   = b;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = b;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = b;
        cnt_nxt = 8'd0;
        xor_nxt = 8'd0;
        if (b == 8'd0) begin
          // empty frame ends at its length byte
          ent.has_ver = 1'b1;
          ent.ver_ok  = (exp_r == 8'd0);
          ent.ver_cmd = cmd_r;
          cmd_nxt     = 8'd0;
          phase_nxt   = PH_IDLE;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        ent.has_pay  = 1'b1;
        ent.pay_byte = b;
        ent.pay_pos  = cnt_r;
        ent.pay_cmd  = cmd_r;
        if (final_byte) begin
          ent.has_ver = 1'b1;
          ent.ver_ok  = (xor_new == exp_r);
          ent.ver_cmd = cmd_r;
          cmd_nxt     = 8'd0;
          cnt_nxt     = 8'd0;
          xor_nxt     = 8'd0;
          phase_nxt   = PH_IDLE;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
          xor_nxt = xor_new;
        end
      end
      default: begin
        // idle: wait for the start byte, ignore noise
        if (b == cfg.start_byte) begin
          phase_nxt = PH_CHECK;
          xor_nxt   = 8'd0;
          cnt_nxt   = 8'd0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  assign push       = take && (ent.has_pay || ent.has_ver);
  assign push_entry = ent;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      exp_r   <= 8'd0;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      xor_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

// ----- rtl/core/xcfr_queue.sv -----
`timescale 1ns / 1ps
// short fifo of work entries between front and back
// depends on xcfr_pkg

module xcfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xcfr_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output xcfr_pkg::entry_t  head
);

  xcfr_pkg::entry_t                 mem_r [xcfr_pkg::QDEPTH];
  logic [xcfr_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [xcfr_pkg::QCNT_W-1:0]      cnt_r;
  logic                             do_push, do_pop;

  assign full    = (cnt_r == xcfr_pkg::QCNT_W'(xcfr_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/xcfr_back.sv -----
`timescale 1ns / 1ps
// back part: expands queue entries into payload and verdict result beats
// depends on xcfr_pkg and xcfr_if

module xcfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xcfr_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  xcfr_pkg::entry_t  head,
  output logic              pop,
  xcfr_out_if.source        out_ch
);

  logic       valid_r;
  logic       pay_done_r, pay_done_nxt;
  logic [1:0] kind_r;
  logic [7:0] value_r, pos_r, cmd_r;
  logic       last_r;

  logic       slot_free;
  logic       load;
  logic       emit_pay;

  assign slot_free = !valid_r || out_ch.ready;
  assign load      = slot_free && !q_empty;
  assign emit_pay  = head.has_pay && !pay_done_r;

  // pop once the entry's final result is loaded
  always_comb begin
    pop          = 1'b0;
    pay_done_nxt = pay_done_r;
    if (load) begin
      if (emit_pay && head.has_ver) begin
        pay_done_nxt = 1'b1;
      end else begin
        pop          = 1'b1;
        pay_done_nxt = 1'b0;
      end
    end
  end

  // control of the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pay_done_r <= 1'b0;
    end else begin
      pay_done_r <= pay_done_nxt;
      if (slot_free) begin
        valid_r <= !q_empty;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_pay) begin
        kind_r  <= xcfr_pkg::KIND_PAYLOAD;
        value_r <= head.pay_byte;
        pos_r   <= head.pay_pos;
        cmd_r   <= head.pay_cmd;
        last_r  <= !head.has_ver;
      end else if (head.ver_ok) begin
        kind_r  <= xcfr_pkg::KIND_ACCEPT;
        value_r <= cfg.ack_code;
        pos_r   <= 8'd0;
        cmd_r   <= head.ver_cmd;
        last_r  <= 1'b1;
      end else begin
        kind_r  <= xcfr_pkg::KIND_REJECT;
        value_r <= cfg.nak_code;
        pos_r   <= 8'd0;
        cmd_r   <= 8'd0;
        last_r  <= 1'b1;
      end
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.value    = value_r;
  assign out_ch.position = pos_r;
  assign out_ch.command  = cmd_r;
  assign out_ch.last     = last_r;

endmodule

// ----- rtl/core/xor_checked_frame_receiver.sv -----
`timescale 1ns / 1ps
// Frame receiver with xor check: takes one received byte per beat and parses frames of start
// byte, check byte, command, length and payload. Each payload byte comes out as it arrives, and
// after the last one (or at a zero length byte) an accept or reject verdict follows. A byte is
// taken every cycle while the four-entry work queue between parser and output stage has room;
// the output stage delivers one result per cycle while the receiver is ready, so a final payload
// byte, which causes two results, occupies it for both and the queue absorbs that. Results leave
// through an output register; a byte's work passes the queue storage and then that register.
// Depends on xcfr_pkg, xcfr_if, xcfr_regs, xcfr_front, xcfr_queue and xcfr_back.

module xor_checked_frame_receiver (
  input  logic         clk,
  input  logic         rst_n,
  xcfr_in_if.sink      in_ch,
  xcfr_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  xcfr_pkg::cfg_t   cfg;
  xcfr_pkg::entry_t push_entry;
  xcfr_pkg::entry_t head;
  logic             push, pop, q_full, q_empty;

  // configuration registers
  xcfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // parser
  xcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // work queue
  xcfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // result stage
  xcfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
